// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of this block.
// Each macro samples on the rising clock edge and is disabled while the
// active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every sampled edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The expression must never be true at a sampled edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// ===== rtl/core/scnh_pkg.sv =====
package scnh_pkg;

	localparam logic [31:0] CRC_POLY_REFL = 32'h82F6_3B78;
	localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
	localparam logic [31:0] KEY_TOP_BIT   = 32'h8000_0000;
	localparam logic [31:0] KEY_MIX_MASK  = 32'hFFFF_0000;
	localparam logic [31:0] KEY_LOW_BIT   = 32'h0000_8000;

	localparam logic [7:0] SEP_DOT   = 8'h2E;
	localparam logic [7:0] SEP_DASH  = 8'h2D;
	localparam logic [7:0] SEP_UNDER = 8'h5F;
	localparam logic [7:0] SEP_TILDE = 8'h7E;

	typedef struct packed {
		logic [7:0] name_byte;
		logic       byte_valid;
		logic       is_last;
	} scnh_item_t;

	// One byte of reflected CRC32C; unrolls into a flat xor network.
	function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] r;
		r = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY_REFL) : (r >> 1);
		end
		return r;
	endfunction

	function automatic logic is_sep(input logic [7:0] b);
		return (b == SEP_DOT) || (b == SEP_DASH) || (b == SEP_UNDER) || (b == SEP_TILDE);
	endfunction

endpackage

// ===== rtl/core/scnh_in_if.sv =====
interface scnh_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] name_byte;
	logic       byte_valid;
	logic       is_last;

	modport source(output valid, output name_byte, output byte_valid, output is_last,
		input ready);
	modport sink(input valid, input name_byte, input byte_valid, input is_last,
		output ready);
endinterface

// ===== rtl/core/scnh_out_if.sv =====
interface scnh_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] hash_key;

	modport source(output valid, output hash_key, input ready);
	modport sink(input valid, input hash_key, output ready);
endinterface

// ===== rtl/core/scnh_accum.sv =====
`include "assert_macros.svh"

module scnh_accum (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  scnh_pkg::scnh_item_t item,
	output logic [63:0]        key
);
	import scnh_pkg::*;

	logic [31:0] whole_crc_q;
	logic [31:0] seg_crc_q;
	logic        nonempty_q;
	logic [31:0] sum_q;

	logic        sep;
	logic        seg_byte;
	logic        close_seg;
	logic [31:0] whole_crc_d;
	logic [31:0] seg_crc_d;
	logic        nonempty_d;
	logic [31:0] sum_d;
	logic [31:0] mix_w;

	always_comb begin
		sep         = item.byte_valid && is_sep(item.name_byte);
		seg_byte    = item.byte_valid && !sep;
		close_seg   = sep || item.is_last;
		whole_crc_d = item.byte_valid ? crc32c_byte(whole_crc_q, item.name_byte) : whole_crc_q;
		seg_crc_d   = seg_byte ? crc32c_byte(seg_crc_q, item.name_byte) : seg_crc_q;
		nonempty_d  = nonempty_q || seg_byte;
		sum_d       = (close_seg && nonempty_d) ? (sum_q + ~seg_crc_d) : sum_q;
		mix_w       = ~whole_crc_d;
		key         = {sum_d | KEY_TOP_BIT,
			((mix_w ^ (mix_w << 16)) & KEY_MIX_MASK) | KEY_LOW_BIT};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			whole_crc_q <= CRC_INIT;
			seg_crc_q   <= CRC_INIT;
			nonempty_q  <= 1'b0;
			sum_q       <= 32'd0;
		end else if (step) begin
			if (item.is_last) begin
				whole_crc_q <= CRC_INIT;
				seg_crc_q   <= CRC_INIT;
				nonempty_q  <= 1'b0;
				sum_q       <= 32'd0;
			end else begin
				whole_crc_q <= whole_crc_d;
				seg_crc_q   <= close_seg ? CRC_INIT : seg_crc_d;
				nonempty_q  <= close_seg ? 1'b0 : nonempty_d;
				sum_q       <= sum_d;
			end
		end
	end

	`ASSERT_CLK(a_clear_after_key, clk, arst_n, step && item.is_last |=> whole_crc_q == CRC_INIT && seg_crc_q == CRC_INIT && sum_q == 32'd0 && !nonempty_q, "state not cleared after a key")
	`ASSERT_CLK(a_idle_holds, clk, arst_n, !step || (!item.byte_valid && !item.is_last) |=> $stable(whole_crc_q) && $stable(seg_crc_q) && $stable(sum_q) && $stable(nonempty_q), "state changed without a byte")
	`ASSERT_CLK(a_sep_closes, clk, arst_n, step && sep && !item.is_last |=> seg_crc_q == CRC_INIT && !nonempty_q, "separator did not close the segment")

endmodule

// ===== rtl/core/scnh_out_reg.sv =====
module scnh_out_reg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  logic [63:0] key_d,
	output logic        can_load,
	scnh_out_if.source  result
);
	logic        valid_q;
	logic [63:0] key_q;

	assign can_load        = !valid_q || result.ready;
	assign result.valid    = valid_q;
	assign result.hash_key = key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			key_q <= key_d;
		end
	end

endmodule

// ===== rtl/core/segmented_crc32c_name_hash_core.sv =====
// Directory hash of a file name, one name byte per transfer.
// Channel name (sink): name_byte, byte_valid and is_last with valid/ready.
// A transfer with byte_valid high adds one byte to the name; is_last high
// closes the name, after its byte if byte_valid is also high. A transfer with
// both low changes nothing. Channel key (source): hash_key with valid/ready,
// one transfer per name.
// Throughput is one name byte per cycle: the byte-wide CRC32C update, the
// separator check and the 32-bit segment sum sit between the input stage
// register and the key register. A closing transfer waits in the input stage
// register until the key register can take its key, which is then loaded
// and shown. The key register lets the next name start while a key waits.
// When the receiver stalls with a key pending, byte transfers keep flowing;
// only a second closing transfer waits in the input stage, and then ready on
// name drops until the pending key is taken.
// Reset clears the stage and key valid flags and returns the running CRCs,
// the segment flag and the segment sum to their start values. The CRCs, the
// segment flag and the sum return to those values after each key as well.
`include "assert_macros.svh"

module segmented_crc32c_name_hash_core (
	input  logic      clk,
	input  logic      arst_n,
	scnh_in_if.sink   name,
	scnh_out_if.source key
);
	import scnh_pkg::*;

	logic        s1_valid_q;
	scnh_item_t  item_s1;
	logic        advance;
	logic        load;
	logic        can_load;
	logic [63:0] key_d;

	// An item without the last mark never waits on the key register.
	assign advance    = s1_valid_q && (!item_s1.is_last || can_load);
	assign load       = advance && item_s1.is_last;
	assign name.ready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (name.valid && name.ready) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (name.valid && name.ready) begin
			item_s1 <= '{name_byte: name.name_byte, byte_valid: name.byte_valid,
				is_last: name.is_last};
		end
	end

	scnh_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.key    (key_d)
	);

	scnh_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.key_d    (key_d),
		.can_load (can_load),
		.result   (key)
	);

	`ASSERT_CLK(a_key_fixed_bits, clk, arst_n,
		key.valid |-> key.hash_key[63] && key.hash_key[15] && key.hash_key[14:0] == 15'd0,
		"fixed key bits wrong")
	`ASSERT_CLK(a_stall_cause, clk, arst_n,
		!name.ready |-> s1_valid_q && item_s1.is_last && key.valid && !key.ready,
		"input stalled without a pending key")
	`ASSERT_CLK(a_load_shows, clk, arst_n, load |=> key.valid, "loaded key not shown")

endmodule

// ===== test/tb_segmented_crc32c_name_hash_core.sv =====
`timescale 1ns / 100ps

// Testbench of the segmented CRC32C directory hash core.
// Name bytes are sent one transfer at a time on the name channel. A
// monitor on that channel runs a predictor of the hash at every accepted
// transfer and queues the key that a closing transfer must produce. A
// second monitor on the key channel compares each accepted key with the
// oldest queued one. Both channels idle at random, and the test tasks
// switch the idling on and off so that stretches of full-rate traffic,
// heavy key back-pressure and drained pauses all occur.
module tb_segmented_crc32c_name_hash_core;
	import scnh_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int TAIL_CYCLES  = 12;
	localparam int REPORT_MAX   = 10;

	logic clk;
	logic arst_n;

	scnh_in_if  name_ch();
	scnh_out_if key_ch();

	segmented_crc32c_name_hash_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.name   (name_ch),
		.key    (key_ch)
	);

	// Predictor state: running CRC registers of the whole name and of the
	// current segment, whether that segment holds a byte, and the sum of
	// the finished segment CRCs.
	logic [31:0] whole_crc;
	logic [31:0] seg_crc;
	logic        seg_open;
	logic [31:0] seg_sum;

	// Keys that the block still owes, oldest first.
	logic [63:0] owed_keys[$];

	int fail_count;
	int sent_items;
	int cycle_count;

	// Idling controls, changed by the test tasks between phases.
	bit src_idle_en;
	bit sink_idle_en;
	bit sink_heavy;

	always begin
		clk = 1'b1;
		#CLK_HALF;
		clk = 1'b0;
		#CLK_HALF;
	end

	// Bit-serial form of the reflected CRC32C: each input bit, least
	// significant first, is folded into the low end of the register.
	function automatic logic [31:0] crc32c_shift_byte(input logic [31:0] crc,
		input logic [7:0] data);
		logic [31:0] r;
		logic        fb;
		r = crc;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ data[i];
			r = r >> 1;
			if (fb)
				r = r ^ CRC_POLY_REFL;
		end
		return r;
	endfunction

	function automatic bit is_separator(input logic [7:0] data);
		return data == SEP_DOT || data == SEP_DASH || data == SEP_UNDER ||
			data == SEP_TILDE;
	endfunction

	function automatic logic [7:0] pick_separator();
		case ($urandom_range(3))
			0: return SEP_DOT;
			1: return SEP_DASH;
			2: return SEP_UNDER;
			default: return SEP_TILDE;
		endcase
	endfunction

	// Idle lengths: mostly none or short, now and then long. The heavy
	// profile is used to hold keys back for long stretches.
	function automatic int idle_length(input bit heavy);
		int r;
		r = $urandom_range(99);
		if (heavy) begin
			if (r < 30)
				return 0;
			else if (r < 60)
				return $urandom_range(1, 4);
			else if (r < 85)
				return $urandom_range(5, 20);
			else
				return $urandom_range(21, 60);
		end
		if (r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 50);
	endfunction

	task automatic clear_hash_state();
		whole_crc = CRC_INIT;
		seg_crc   = CRC_INIT;
		seg_open  = 1'b0;
		seg_sum   = 32'd0;
	endtask

	// A separator or the end of the name closes the current segment; an
	// empty segment adds nothing to the sum.
	task automatic close_segment();
		if (seg_open)
			seg_sum = seg_sum + ~seg_crc;
		seg_crc  = CRC_INIT;
		seg_open = 1'b0;
	endtask

	// Applies one accepted transfer to the predictor. A byte goes in before
	// the name closes, so a last byte is part of the key it produces.
	task automatic hash_name_transfer(input logic [7:0] data, input logic bv,
		input logic closes);
		logic [31:0] upper;
		logic [31:0] w;
		logic [31:0] lower;
		if (bv) begin
			whole_crc = crc32c_shift_byte(whole_crc, data);
			if (is_separator(data)) begin
				close_segment();
			end else begin
				seg_crc  = crc32c_shift_byte(seg_crc, data);
				seg_open = 1'b1;
			end
		end
		if (closes) begin
			close_segment();
			upper = seg_sum | KEY_TOP_BIT;
			w = ~whole_crc;
			lower = ((w ^ (w << 16)) & KEY_MIX_MASK) | KEY_LOW_BIT;
			owed_keys.push_back({upper, lower});
			clear_hash_state();
		end
	endtask

	task automatic note_failure(input string what, input logic [63:0] want,
		input logic [63:0] got);
		fail_count++;
		if (fail_count <= REPORT_MAX)
			$display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
	endtask

	// Input monitor: every accepted name transfer feeds the predictor. The
	// inputs were set at the falling edge, so their values are settled here.
	always @(posedge clk) begin
		if (arst_n && name_ch.valid && name_ch.ready)
			hash_name_transfer(name_ch.name_byte, name_ch.byte_valid, name_ch.is_last);
	end

	// Key monitor: every accepted key is matched against the oldest owed key.
	always @(posedge clk) begin
		if (arst_n && key_ch.valid && key_ch.ready) begin
			if (owed_keys.size() == 0)
				note_failure("key with none owed", 64'd0, key_ch.hash_key);
			else if (key_ch.hash_key !== owed_keys[0])
				note_failure("hash_key mismatch", owed_keys.pop_front(), key_ch.hash_key);
			else
				void'(owed_keys.pop_front());
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Key receiver: ready is held high, then may drop for a random stall.
	// With idling off it stays high.
	initial begin
		int stall;
		key_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			key_ch.ready = 1'b1;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			if (sink_idle_en) begin
				stall = idle_length(sink_heavy);
				if (stall > 0) begin
					key_ch.ready = 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
		end
	end

	// Sends one transfer on the name channel. It is entered at a falling
	// edge and returns at one. With no gap, valid stays high so the next
	// transfer follows at once; the caller lowers it when the stream stops.
	task automatic send_transfer(input logic [7:0] data, input logic bv,
		input logic closes);
		int gap;
		name_ch.name_byte  = data;
		name_ch.byte_valid = bv;
		name_ch.is_last    = closes;
		name_ch.valid      = 1'b1;
		do
			@(posedge clk);
		while (!name_ch.ready);
		if (bv || closes)
			sent_items++;
		@(negedge clk);
		gap = src_idle_en ? idle_length(1'b0) : 0;
		if (gap > 0) begin
			name_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Holds the sender until every owed key has been taken.
	task automatic wait_keys_drained();
		name_ch.valid = 1'b0;
		while (owed_keys.size() != 0)
			@(negedge clk);
	endtask

	// One well-formed name with random content. Separators are frequent so
	// that empty, doubled, leading and trailing segments all turn up, and an
	// ignored idle transfer is slipped in now and then.
	task automatic send_random_name(input int max_len);
		int len;
		bit close_on_byte;
		logic [7:0] data;
		len = ($urandom_range(99) < 4) ? $urandom_range(max_len, 4 * max_len) :
			$urandom_range(max_len);
		close_on_byte = (len > 0) && ($urandom_range(99) < 70);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 5)
				send_transfer(8'($urandom_range(255)), 1'b0, 1'b0);
			data = ($urandom_range(99) < 25) ? pick_separator() : 8'($urandom_range(255));
			send_transfer(data, 1'b1, close_on_byte && i == len - 1);
		end
		if (!close_on_byte)
			send_transfer(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	// Mostly well-formed names, the rest fully random transfers.
	task automatic send_mixed_traffic(input int items, input int max_len);
		int stop_at;
		stop_at = sent_items + items;
		while (sent_items < stop_at) begin
			if ($urandom_range(99) < 85)
				send_random_name(max_len);
			else
				send_transfer(8'($urandom_range(255)), 1'($urandom_range(1)),
					1'($urandom_range(1)));
		end
	endtask

	// Extremes of the byte, the empty name, a single-separator name, a
	// separator as the last byte, leading and doubled separators, a closing
	// transfer after bytes, and idle transfers with a nonzero byte.
	task automatic test_directed();
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		send_transfer(8'hA5, 1'b0, 1'b1);
		send_transfer(8'h00, 1'b1, 1'b1);
		send_transfer(8'hFF, 1'b1, 1'b1);
		send_transfer(SEP_DOT, 1'b1, 1'b0);
		send_transfer(SEP_DOT, 1'b1, 1'b0);
		send_transfer(8'h61, 1'b1, 1'b0);
		send_transfer(8'h5A, 1'b0, 1'b0);
		send_transfer(SEP_DASH, 1'b1, 1'b0);
		send_transfer(SEP_UNDER, 1'b1, 1'b0);
		send_transfer(8'h62, 1'b1, 1'b0);
		send_transfer(SEP_TILDE, 1'b1, 1'b1);
		send_transfer(8'h78, 1'b1, 1'b0);
		send_transfer(8'hFF, 1'b0, 1'b1);
		send_transfer(SEP_TILDE, 1'b1, 1'b1);
		send_transfer(8'h80, 1'b1, 1'b0);
		send_transfer(8'h7F, 1'b1, 1'b1);
		wait_keys_drained();
	endtask

	// Random names with idling on both sides; the sender stops a few times
	// in the middle until every key has come back.
	task automatic test_random_names();
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
		sink_heavy   = 1'b0;
		for (int i = 0; i < 4; i++) begin
			send_mixed_traffic(220, 12);
			wait_keys_drained();
		end
	endtask

	// Full rate on both sides: short names back to back.
	task automatic test_back_to_back();
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		send_mixed_traffic(200, 3);
		wait_keys_drained();
	endtask

	// Long key stalls against a sender that never idles, so closing
	// transfers pile up behind a pending key and the name channel stalls.
	task automatic test_key_backpressure();
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b1;
		sink_heavy   = 1'b1;
		send_mixed_traffic(250, 4);
		wait_keys_drained();
	endtask

	initial begin
		arst_n             = 1'b0;
		name_ch.valid      = 1'b0;
		name_ch.name_byte  = 8'd0;
		name_ch.byte_valid = 1'b0;
		name_ch.is_last    = 1'b0;
		src_idle_en        = 1'b0;
		sink_idle_en       = 1'b0;
		sink_heavy         = 1'b0;
		fail_count         = 0;
		sent_items         = 0;
		cycle_count        = 0;
		clear_hash_state();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random_names();
		test_back_to_back();
		test_key_backpressure();

		// Give a stray key time to show up before judging the run.
		wait_keys_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (owed_keys.size() != 0)
			note_failure("keys still owed at end", owed_keys[0], 64'd0);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/scnh_pkg.sv
rtl/core/scnh_in_if.sv
rtl/core/scnh_out_if.sv
rtl/core/scnh_accum.sv
rtl/core/scnh_out_reg.sv
rtl/core/segmented_crc32c_name_hash_core.sv
test/tb_segmented_crc32c_name_hash_core.sv
